### rtl/html_tag_strip_entity_decode_unit_defines.svh
// Assertion macros for the tag strip / entity decode unit.
// No dependencies; included by the files that assert.
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_UNIT_DEFINES_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_UNIT_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define HTSED_ASSERT_AT(label, clock, reset_n, prop, msg) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (prop)) \
        else $error(msg);

// Same, on the block's own clk and rst_n.
`define HTSED_ASSERT(label, prop, msg) \
    `HTSED_ASSERT_AT(label, clk, rst_n, prop, msg)

`endif

### rtl/htsed_pkg.sv
// Shared types, character codes and entity tables for the tag strip unit.
// No dependencies.
`default_nettype none

package htsed_pkg;

    localparam int MaxEmit = 6;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] count_t;

    typedef enum logic [1:0] {
        KIND_QUOT,
        KIND_LT,
        KIND_GT,
        KIND_AMP
    } kind_t;

    localparam byte_t CharLt    = 8'h3C;
    localparam byte_t CharGt    = 8'h3E;
    localparam byte_t CharAmp   = 8'h26;
    localparam byte_t CharSemi  = 8'h3B;
    localparam byte_t CharQuote = 8'h22;
    localparam byte_t CharQ     = 8'h71;
    localparam byte_t CharU     = 8'h75;
    localparam byte_t CharO     = 8'h6F;
    localparam byte_t CharT     = 8'h74;
    localparam byte_t CharL     = 8'h6C;
    localparam byte_t CharG     = 8'h67;
    localparam byte_t CharA     = 8'h61;
    localparam byte_t CharM     = 8'h6D;
    localparam byte_t CharP     = 8'h70;

    typedef struct packed {
        logic   inside_tag;
        kind_t  entity_kind;
        count_t match_count;
    } scan_state_t;

    typedef struct packed {
        logic [MaxEmit-1:0][7:0] bytes;
        count_t                  count;
    } emit_t;

    function automatic byte_t ent_char(kind_t kind, count_t idx);
        byte_t b;
        b = 8'h00;
        case (kind)
            KIND_QUOT:
                case (idx)
                    3'd0:    b = CharAmp;
                    3'd1:    b = CharQ;
                    3'd2:    b = CharU;
                    3'd3:    b = CharO;
                    3'd4:    b = CharT;
                    3'd5:    b = CharSemi;
                    default: b = 8'h00;
                endcase
            KIND_LT:
                case (idx)
                    3'd0:    b = CharAmp;
                    3'd1:    b = CharL;
                    3'd2:    b = CharT;
                    3'd3:    b = CharSemi;
                    default: b = 8'h00;
                endcase
            KIND_GT:
                case (idx)
                    3'd0:    b = CharAmp;
                    3'd1:    b = CharG;
                    3'd2:    b = CharT;
                    3'd3:    b = CharSemi;
                    default: b = 8'h00;
                endcase
            default:
                case (idx)
                    3'd0:    b = CharAmp;
                    3'd1:    b = CharA;
                    3'd2:    b = CharM;
                    3'd3:    b = CharP;
                    3'd4:    b = CharSemi;
                    default: b = 8'h00;
                endcase
        endcase
        return b;
    endfunction

    function automatic count_t ent_len(kind_t kind);
        count_t n;
        case (kind)
            KIND_QUOT: n = 3'd6;
            KIND_LT:   n = 3'd4;
            KIND_GT:   n = 3'd4;
            default:   n = 3'd5;
        endcase
        return n;
    endfunction

    function automatic byte_t ent_value(kind_t kind);
        byte_t b;
        case (kind)
            KIND_QUOT: b = CharQuote;
            KIND_LT:   b = CharLt;
            KIND_GT:   b = CharGt;
            default:   b = CharAmp;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### rtl/htsed_step.sv
// One-byte scan step: next tag/entity state and the bytes the byte releases.
// Depends on htsed_pkg.
`default_nettype none

module htsed_step (
    input  logic [7:0]                char_in,
    input  logic                      final_byte,
    input  htsed_pkg::scan_state_t    state_cur,
    output htsed_pkg::scan_state_t    state_next,
    output htsed_pkg::emit_t          emit
);
    import htsed_pkg::*;

    scan_state_t st;
    count_t      pre_len;
    kind_t       pre_kind;
    logic        mid_en;
    byte_t       mid_byte;
    count_t      post_len;
    kind_t       post_kind;
    logic        do_plain;
    count_t      pos_next;

    // Emission order: flushed prefix, single byte, then prefix left at end of text.
    always_comb
    begin
        st        = state_cur;
        pre_len   = '0;
        pre_kind  = state_cur.entity_kind;
        mid_en    = 1'b0;
        mid_byte  = '0;
        post_len  = '0;
        post_kind = KIND_QUOT;
        do_plain  = 1'b0;
        pos_next  = state_cur.match_count + 3'd1;

        if (state_cur.inside_tag)
        begin
            if (char_in == CharGt)
            begin
                st.inside_tag = 1'b0;
            end
        end
        else if (state_cur.match_count == 3'd0)
        begin
            do_plain = 1'b1;
        end
        else if (state_cur.match_count == 3'd1)
        begin
            case (char_in)
                CharQ:
                begin
                    st.entity_kind = KIND_QUOT;
                    st.match_count = 3'd2;
                end
                CharL:
                begin
                    st.entity_kind = KIND_LT;
                    st.match_count = 3'd2;
                end
                CharG:
                begin
                    st.entity_kind = KIND_GT;
                    st.match_count = 3'd2;
                end
                CharA:
                begin
                    st.entity_kind = KIND_AMP;
                    st.match_count = 3'd2;
                end
                default:
                begin
                    pre_len        = 3'd1;
                    st.match_count = 3'd0;
                    st.entity_kind = KIND_QUOT;
                    do_plain       = 1'b1;
                end
            endcase
        end
        else
        begin
            if ((state_cur.match_count < ent_len(state_cur.entity_kind)) &&
                (char_in == ent_char(state_cur.entity_kind, state_cur.match_count)))
            begin
                if (pos_next == ent_len(state_cur.entity_kind))
                begin
                    // no byte follows: entity stays literal
                    if (final_byte)
                    begin
                        pre_len = pos_next;
                    end
                    else
                    begin
                        mid_en   = 1'b1;
                        mid_byte = ent_value(state_cur.entity_kind);
                    end
                    st.match_count = 3'd0;
                    st.entity_kind = KIND_QUOT;
                end
                else
                begin
                    st.match_count = pos_next;
                end
            end
            else
            begin
                pre_len        = state_cur.match_count;
                st.match_count = 3'd0;
                st.entity_kind = KIND_QUOT;
                do_plain       = 1'b1;
            end
        end

        if (do_plain)
        begin
            case (char_in)
                CharLt:
                begin
                    st.inside_tag = 1'b1;
                end
                CharGt:
                begin
                    // stray close bracket: dropped
                end
                CharAmp:
                begin
                    st.match_count = 3'd1;
                    st.entity_kind = KIND_QUOT;
                end
                default:
                begin
                    mid_en   = 1'b1;
                    mid_byte = char_in;
                end
            endcase
        end

        if (final_byte)
        begin
            post_len  = st.match_count;
            post_kind = st.entity_kind;
            st        = '0;
        end
    end

    assign state_next = st;

    always_comb
    begin
        emit.bytes = '0;
        for (int j = 0; j < MaxEmit; j++)
        begin
            if (count_t'(j) < pre_len)
            begin
                emit.bytes[j] = ent_char(pre_kind, count_t'(j));
            end
            else if (mid_en && (count_t'(j) == pre_len))
            begin
                emit.bytes[j] = mid_byte;
            end
            else
            begin
                emit.bytes[j] = ent_char(post_kind,
                                         count_t'(j) - pre_len - {2'b00, mid_en});
            end
        end
        emit.count = pre_len + {2'b00, mid_en} + post_len;
    end

endmodule

`default_nettype wire

### rtl/html_tag_strip_entity_decode_unit.sv
// Top level: input register, scan step, result buffer that serialises bytes.
// Depends on htsed_pkg, htsed_step and the assertion macro header.
//
//  channel  signals                                    role
//  in       in_valid in_ready char_in final_byte       raw text byte request
//  out      out_valid out_ready char_out has_char      one result per cycle while out_ready is high
//           run_end text_end
//
// A new byte moves on once the buffer is empty or its last result leaves; a
// byte with n results holds the input side while the result buffer drains.
// A byte passes through the input register and then the result buffer.
// The scan state updates when a byte moves from the input register into
// the result buffer; reset clears state, valid flags and the buffer count.
// Stalls on out_ready back up into in_ready through the input register.
`default_nettype none
`include "html_tag_strip_entity_decode_unit_defines.svh"

module html_tag_strip_entity_decode_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out,
    output logic       has_char,
    output logic       run_end,
    output logic       text_end
);
    import htsed_pkg::*;

    logic                    in_valid_reg, in_valid_next;
    byte_t                   char_reg;
    logic                    fin_reg;
    scan_state_t             state_reg, state_next;
    emit_t                   emit;
    logic [MaxEmit-1:0][7:0] res_bytes_reg, res_bytes_next;
    count_t                  res_cnt_reg, res_cnt_next;
    logic                    res_has_reg, res_has_next;
    logic                    res_fin_reg, res_fin_next;
    logic                    advance;
    logic                    out_fire;

    htsed_step u_step (
        .char_in    (char_reg),
        .final_byte (fin_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .emit       (emit)
    );

    assign out_valid = (res_cnt_reg != 3'd0);
    assign out_fire  = out_valid && out_ready;
    assign advance   = in_valid_reg && ((res_cnt_reg == 3'd0) ||
                                        (out_ready && (res_cnt_reg == 3'd1)));
    assign in_ready  = !in_valid_reg || advance;

    assign char_out = res_bytes_reg[0];
    assign has_char = res_has_reg;
    assign run_end  = (res_cnt_reg == 3'd1);
    assign text_end = (res_cnt_reg == 3'd1) && res_fin_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_bytes_next = res_bytes_reg;
        res_cnt_next   = res_cnt_reg;
        res_has_next   = res_has_reg;
        res_fin_next   = res_fin_reg;
        if (advance)
        begin
            res_fin_next = fin_reg;
            if (emit.count == 3'd0)
            begin
                // empty marker
                res_bytes_next = '0;
                res_cnt_next   = 3'd1;
                res_has_next   = 1'b0;
            end
            else
            begin
                res_bytes_next = emit.bytes;
                res_cnt_next   = emit.count;
                res_has_next   = 1'b1;
            end
        end
        else if (out_fire)
        begin
            res_bytes_next = {8'h00, res_bytes_reg[MaxEmit-1:1]};
            res_cnt_next   = res_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            res_cnt_reg  <= '0;
            res_has_reg  <= 1'b0;
            res_fin_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            res_cnt_reg  <= res_cnt_next;
            res_has_reg  <= res_has_next;
            res_fin_reg  <= res_fin_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_bytes_reg <= res_bytes_next;
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
            fin_reg  <= final_byte;
        end
    end

    `HTSED_ASSERT(a_load_visible, advance |=> (res_cnt_reg != 3'd0), "loaded request not shown")
    `HTSED_ASSERT(a_marker_single, !res_has_reg |-> (res_cnt_reg <= 3'd1), "marker spans results")
    `HTSED_ASSERT(a_text_end_clear, (advance && fin_reg) |=> (state_reg == '0), "state kept past end")
    `HTSED_ASSERT(a_tag_no_entity, state_reg.inside_tag |-> (state_reg.match_count == 3'd0), "entity in tag")
    `HTSED_ASSERT(a_count_bound, res_cnt_reg <= 3'(MaxEmit), "result count overflow")

endmodule

`default_nettype wire

### test/tb.sv
// Testbench for html_tag_strip_entity_decode_unit: directed and random texts go
// through a queue-fed driver; a monitor checks results against a byte predictor.
// Depends on htsed_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
    import htsed_pkg::*;

    localparam int HoldLen       = 300;
    localparam int WatchdogLimit = 2000;

    typedef byte_t text_t[$];

    typedef struct packed {
        byte_t ch;
        logic  fin;
    } send_t;

    typedef struct packed {
        byte_t ch;
        logic  has_ch;
        logic  last_of_byte;
        logic  last_of_text;
    } result_t;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] char_in    = 8'h00;
    logic       final_byte = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] char_out;
    logic       has_char;
    logic       run_end;
    logic       text_end;

    send_t   bytes_to_send[$];
    result_t results_due[$];
    byte_t   step_bytes[$];
    int      bytes_queued = 0;
    int      mismatches   = 0;
    int      quiet_cycles = 0;
    int      hold_cycles  = 0;
    int      tx_idle_pct  = 10;
    int      rx_idle_pct  = 49;
    logic    hold_off     = 1'b0;
    logic    in_took      = 1'b0;
    result_t got, want;

    // predictor state
    logic   in_tag    = 1'b0;
    kind_t  cand_kind = KIND_QUOT;
    count_t cand_len  = '0;
    byte_t  decoded[4] = '{CharQuote, CharLt, CharGt, CharAmp};

    html_tag_strip_entity_decode_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .final_byte (final_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .char_out   (char_out),
        .has_char   (has_char),
        .run_end    (run_end),
        .text_end   (text_end)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic string entity_text(kind_t k);
        case (k)
            KIND_QUOT: return "&quot;";
            KIND_LT:   return "&lt;";
            KIND_GT:   return "&gt;";
            default:   return "&amp;";
        endcase
    endfunction

    // matched prefix goes out verbatim
    function automatic void flush_literal();
        string s;
        s = entity_text(cand_kind);
        for (int i = 0; i < cand_len; i++)
        begin
            step_bytes.insert(step_bytes.size(), byte_t'(s[i]));
        end
        cand_len  = '0;
        cand_kind = KIND_QUOT;
    endfunction

    function automatic void scan_plain(byte_t c);
        if (c == CharLt)
        begin
            in_tag = 1'b1;
        end
        else if (c == CharAmp)
        begin
            cand_len  = 3'd1;
            cand_kind = KIND_QUOT;
        end
        else if (c != CharGt)
        begin
            step_bytes.insert(step_bytes.size(), c);
        end
    endfunction

    function automatic void decode_byte(byte_t c, logic fin);
        string s;
        int    n;
        step_bytes.delete();
        if (in_tag)
        begin
            if (c == CharGt)
                in_tag = 1'b0;
        end
        else if (cand_len == 3'd1)
        begin
            case (c)
                CharQ:   begin cand_kind = KIND_QUOT; cand_len = 3'd2; end
                CharL:   begin cand_kind = KIND_LT;   cand_len = 3'd2; end
                CharG:   begin cand_kind = KIND_GT;   cand_len = 3'd2; end
                CharA:   begin cand_kind = KIND_AMP;  cand_len = 3'd2; end
                default:
                begin
                    flush_literal();
                    scan_plain(c);
                end
            endcase
        end
        else if (cand_len >= 3'd2)
        begin
            s = entity_text(cand_kind);
            if (cand_len < s.len() && c == byte_t'(s[cand_len]))
            begin
                cand_len = cand_len + 3'd1;
                if (cand_len == s.len())
                begin
                    if (fin)
                    begin
                        flush_literal();
                    end
                    else
                    begin
                        step_bytes.insert(step_bytes.size(), decoded[cand_kind]);
                        cand_len  = '0;
                        cand_kind = KIND_QUOT;
                    end
                end
            end
            else
            begin
                flush_literal();
                scan_plain(c);
            end
        end
        else
        begin
            scan_plain(c);
        end

        if (fin)
        begin
            if (cand_len != '0)
                flush_literal();
            in_tag    = 1'b0;
            cand_kind = KIND_QUOT;
            cand_len  = '0;
        end

        n = step_bytes.size();
        if (n == 0)
        begin
            results_due.insert(results_due.size(), '{8'h00, 1'b0, 1'b1, fin});
        end
        else
        begin
            foreach (step_bytes[i])
                results_due.insert(results_due.size(),
                                   '{step_bytes[i], 1'b1, i == n - 1, fin && i == n - 1});
        end
    endfunction

    function automatic text_t str_bytes(string s);
        text_t q;
        for (int i = 0; i < s.len(); i++)
            q.insert(q.size(), byte_t'(s[i]));
        return q;
    endfunction

    task automatic queue_text(text_t txt, int noise_pct);
        foreach (txt[i])
        begin
            bytes_to_send.insert(bytes_to_send.size(), '{txt[i],
                i == txt.size() - 1 || $urandom_range(0, 99) < noise_pct});
        end
        bytes_queued += txt.size();
    endtask

    // well-formed entities and tags, broken prefixes, stray brackets and raw noise
    task automatic add_text(int tokens);
        text_t txt;
        string ent;
        int    n;
        if ($urandom_range(0, 99) < 15)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                txt.insert(txt.size(), byte_t'($urandom_range(0, 255)));
        end
        else
        begin
            for (int t = 0; t < tokens; t++)
            begin
                ent = entity_text(kind_t'($urandom_range(0, 3)));
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        for (int i = 0; i < ent.len(); i++)
                            txt.insert(txt.size(), byte_t'(ent[i]));
                    end
                    3:
                    begin
                        n = $urandom_range(1, ent.len() - 1);
                        for (int i = 0; i < n; i++)
                            txt.insert(txt.size(), byte_t'(ent[i]));
                    end
                    4:
                    begin
                        txt.insert(txt.size(), CharLt);
                        n = $urandom_range(0, 4);
                        for (int i = 0; i < n; i++)
                            txt.insert(txt.size(),
                                       $urandom_range(0, 1) ? CharAmp
                                                            : byte_t'($urandom_range(0, 255)));
                        txt.insert(txt.size(), CharGt);
                    end
                    5:
                        txt.insert(txt.size(), CharGt);
                    6:
                        txt.insert(txt.size(), CharAmp);
                    default:
                        txt.insert(txt.size(), byte_t'($urandom_range(0, 255)));
                endcase
            end
        end
        queue_text(txt, 2);
    endtask

    initial
    begin
        queue_text(str_bytes("&quot;>"), 0);
        queue_text(str_bytes("<&<>"), 0);
        queue_text(str_bytes("&g&lt;"), 0);
        queue_text(str_bytes("&l<x>&am"), 0);
        queue_text('{8'hFF, 8'h00}, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin tx_idle_pct = 10; rx_idle_pct = 49; end
                1:       begin tx_idle_pct = 49; rx_idle_pct = 10; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  hold_off = 1'b1; end
            endcase
            while (bytes_queued < 140 * (phase + 1))
                add_text($urandom_range(1, 6));
            while (bytes_to_send.size() != 0)
                @(posedge clk);
        end

        while (results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                in_valid   <= 1'b1;
                char_in    <= bytes_to_send[0].ch;
                final_byte <= bytes_to_send[0].fin;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the unit up
    always @(negedge clk)
    begin
        if (hold_off && hold_cycles < HoldLen)
        begin
            out_ready   <= 1'b0;
            hold_cycles = hold_cycles + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        in_took = rst_n && in_valid && in_ready;
        if (in_took)
        begin
            void'(bytes_to_send.pop_front());
            decode_byte(char_in, final_byte);
        end

        if (rst_n && out_valid && out_ready)
        begin
            got = '{char_out, has_char, run_end, text_end};
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: char %h has %b run %b text %b",
                             got.ch, got.has_ch, got.last_of_byte, got.last_of_text);
            end
            else
            begin
                want = results_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected char %h has %b run %b text %b, ",
                                  "got char %h has %b run %b text %b"},
                                 want.ch, want.has_ch, want.last_of_byte, want.last_of_text,
                                 got.ch, got.has_ch, got.last_of_byte, got.last_of_text);
                end
            end
        end

        if (in_took || (rst_n && out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
